### hw/rtl/abre_pkg.sv
package abre_pkg;

  // Default geometry of the bitmap
  localparam int unsigned WORD_COUNT_DEF = 1024;
  localparam int unsigned WORD_BITS_DEF  = 64;

  // Fixed field widths
  localparam int unsigned TYPE_W = 2;
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned LEN_W  = 17;
  // Wide enough for WORD_COUNT * WORD_BITS at the largest geometry
  localparam int unsigned TOT_W  = 23;
  // Scale of the reciprocal used to split a bit index into word and offset
  localparam int unsigned DIV_SHIFT = 22;

  // Request kinds
  localparam logic [TYPE_W-1:0] REQ_READ = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_GET_SET = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_FILL = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_step;
    logic load_req;
    logic div1;
    logic div2;
    logic div3;
    logic rd;
    logic wr;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic skip;
    logic walk_last;
  } stat_t;

endpackage

### hw/rtl/abre_ctrl.sv
module abre_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  abre_pkg::stat_t st,
  output abre_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV1  = 3'd2;
  localparam logic [2:0] S_DIV2  = 3'd3;
  localparam logic [2:0] S_DIV3  = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_WR    = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Sequence one request through split, walk and result
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DIV1;
        end
      end
      S_DIV1: begin
        cmd.div1  = 1'b1;
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        cmd.div2  = 1'b1;
        state_nxt = S_DIV3;
      end
      S_DIV3: begin
        cmd.div3  = 1'b1;
        state_nxt = st.skip ? S_FIN : S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = st.walk_last ? S_FIN : S_RD;
      end
      S_FIN: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/abre_dp.sv
module abre_dp #(
  parameter int unsigned WORD_COUNT = abre_pkg::WORD_COUNT_DEF,
  parameter int unsigned WORD_BITS  = abre_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  abre_pkg::cmd_t                cmd,
  output abre_pkg::stat_t               st,
  input  logic [abre_pkg::TYPE_W-1:0]   in_req_type,
  input  logic [abre_pkg::IDX_W-1:0]    in_bit_index,
  input  logic [abre_pkg::LEN_W-1:0]    in_run_length,
  input  logic                          in_new_value,
  output logic                          out_old_bit,
  output logic                          out_status
);

  localparam int unsigned AW      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned OW      = $clog2(WORD_BITS);
  localparam int unsigned IW      = abre_pkg::IDX_W;
  localparam int unsigned LW      = abre_pkg::LEN_W;
  localparam int unsigned TW      = abre_pkg::TOT_W;
  localparam int unsigned SH      = abre_pkg::DIV_SHIFT;
  localparam int unsigned RECIP_W = SH - 2;
  localparam int unsigned RECIP   = (1 << SH) / WORD_BITS;
  localparam int unsigned TOTAL   = WORD_COUNT * WORD_BITS;

  // Request registers
  logic [abre_pkg::TYPE_W-1:0] type_r;
  logic [IW-1:0]               idx_r;
  logic [LW-1:0]               len_r;
  logic                        val_r;

  // Index split and walk registers
  logic [IW+RECIP_W-1:0] prod1_r;
  logic [IW-1:0]         q0_r;
  logic [AW-1:0]         word_r;
  logic [OW-1:0]         off_r;
  logic [LW-1:0]         left_r;
  logic                  err_r;
  logic                  old_r;
  logic [AW-1:0]         clr_addr_r;

  // Bitmap memory
  logic [WORD_BITS-1:0]  mem [WORD_COUNT];
  logic [WORD_BITS-1:0]  rdata_r;

  logic                  out_old_bit_r;
  logic                  out_status_r;

  // Split and range check
  logic [IW+6:0]         prod2;
  logic [IW-1:0]         rem0;
  logic                  corr;
  logic [TW-1:0]         end_sum;
  logic                  is_run;
  logic                  err_c;
  logic                  skip_c;

  // Walk step
  logic [LW-1:0]         avail;
  logic [LW-1:0]         n_bits;
  logic [WORD_BITS-1:0]  mask;
  logic [WORD_BITS-1:0]  wdata;
  logic                  we;
  logic [AW-1:0]         waddr;

  assign prod2   = (IW + 7)'(q0_r * (IW + 7)'(WORD_BITS));
  assign rem0    = idx_r - prod2[IW-1:0];
  assign corr    = (rem0 >= IW'(WORD_BITS));
  assign end_sum = TW'(idx_r) + TW'(len_r);
  assign is_run  = (type_r == abre_pkg::REQ_FILL);

  // Decide range error and whether memory is touched at all
  always_comb begin
    if (is_run) begin
      err_c  = (len_r != '0) && (end_sum > TW'(TOTAL));
      skip_c = (len_r == '0) || err_c;
    end else begin
      err_c  = (TW'(idx_r) >= TW'(TOTAL));
      skip_c = err_c;
    end
  end

  // Bits touched in the current word
  assign avail  = LW'(WORD_BITS) - LW'(off_r);
  assign n_bits = (left_r < avail) ? left_r : avail;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = (LW'(i) >= LW'(off_r)) && (LW'(i) < (LW'(off_r) + n_bits));
    end
  end

  assign wdata = val_r ? (rdata_r | mask) : (rdata_r & ~mask);

  assign st.clr_last  = (clr_addr_r == AW'(WORD_COUNT - 1));
  assign st.skip      = skip_c;
  assign st.walk_last = (left_r == n_bits);

  // Request, split and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      type_r <= in_req_type;
      idx_r  <= in_bit_index;
      len_r  <= in_run_length;
      val_r  <= in_new_value;
      old_r  <= 1'b0;
    end
    if (cmd.div1) begin
      prod1_r <= (IW + RECIP_W)'(idx_r * RECIP_W'(RECIP));
    end
    if (cmd.div2) begin
      q0_r <= IW'(prod1_r[IW+RECIP_W-1:SH]);
    end
    if (cmd.div3) begin
      word_r <= corr ? AW'(q0_r + IW'(1)) : AW'(q0_r);
      off_r  <= corr ? OW'(rem0 - IW'(WORD_BITS)) : OW'(rem0);
      left_r <= is_run ? len_r : LW'(1);
      err_r  <= err_c;
    end
    if (cmd.wr) begin
      if ((type_r == abre_pkg::REQ_READ) || (type_r == abre_pkg::REQ_GET_SET)) begin
        old_r <= rdata_r[off_r];
      end
      word_r <= word_r + AW'(1);
      off_r  <= '0;
      left_r <= left_r - n_bits;
    end
    if (cmd.load_out) begin
      out_old_bit_r <= old_r;
      out_status_r  <= err_r;
    end
  end

  // Advance the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step && !st.clr_last) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  assign we    = cmd.clr_step || (cmd.wr && (type_r != abre_pkg::REQ_READ));
  assign waddr = cmd.clr_step ? clr_addr_r : word_r;

  // Memory port: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= cmd.clr_step ? '0 : wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[word_r];
    end
  end

  assign out_old_bit = out_old_bit_r;
  assign out_status  = out_status_r;

endmodule

### hw/rtl/allocation_bitmap_run_engine.sv
// Channel  Handshake               Payload
// in       in_valid / in_ready     in_req_type, in_bit_index, in_run_length, in_new_value
// out      out_valid / out_ready   out_old_bit, out_status
//
// A single-bit request passes the states DIV1, DIV2 and DIV3, which split the index by
// reciprocal multiply, then a read state, a write state and the load of the result.
// A run fill repeats the read and write states per word touched; a request that touches
// nothing skips them. in_ready rises with out_valid, so a new request is taken only after the last.
// After reset a clearing pass zeroes the memory word by word, with in_ready low.
// A result waits in the output register; a stall holds the block only at the next result.
module allocation_bitmap_run_engine #(
  parameter int unsigned WORD_COUNT = abre_pkg::WORD_COUNT_DEF,
  parameter int unsigned WORD_BITS  = abre_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [abre_pkg::TYPE_W-1:0] in_req_type,
  input  logic [abre_pkg::IDX_W-1:0]  in_bit_index,
  input  logic [abre_pkg::LEN_W-1:0]  in_run_length,
  input  logic                        in_new_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_old_bit,
  output logic                        out_status
);

  abre_pkg::cmd_t  cmd;
  abre_pkg::stat_t st;

  // Sequence requests
  abre_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Hold the bitmap and do the arithmetic
  abre_dp #(
    .WORD_COUNT (WORD_COUNT),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_req_type   (in_req_type),
    .in_bit_index  (in_bit_index),
    .in_run_length (in_run_length),
    .in_new_value  (in_new_value),
    .out_old_bit   (out_old_bit),
    .out_status    (out_status)
  );

endmodule
